### rtl/cfr_pkg.sv
// cfr_pkg: shared widths, constants, state type and control structs
// used by every file of the continued fraction to rational block
// no dependencies
package cfr_pkg;

    localparam int FRAC_BITS = 32;
    localparam int MAX_STEPS = 64;
    localparam int VALUE_W   = 64;
    localparam int DEN_W     = 32;
    localparam int H_W       = VALUE_W - 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int SHIFT_W   = $clog2(VALUE_W);

    localparam logic [DEN_W-1:0] MAX_DEN_RESET = DEN_W'(65535);
    localparam logic [Q_W-1:0]   Q_INIT        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(MAX_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_DIVIDE,
        ST_UPDATE,
        ST_DONE
    } cfr_state_t;

    typedef struct packed {
        logic start;
        logic align_shift;
        logic div_step;
        logic update_step;
        logic load_out;
    } cfr_ctrl_t;

    typedef struct packed {
        logic align_more;
        logic div_overflow;
        logic div_last;
        logic upd_reject;
        logic upd_stop;
    } cfr_stat_t;

endpackage

### rtl/cfr_datapath.sv
// cfr_datapath: shared shift-subtract divider with serial convergent update
// holds remainder, divisor, convergents and quotient products
// depends on cfr_pkg
module cfr_datapath (
    input  logic                              clk,
    input  cfr_pkg::cfr_ctrl_t                ctrl,
    input  logic signed [cfr_pkg::VALUE_W-1:0] value_fixed,
    input  logic [cfr_pkg::DEN_W-1:0]         limit,
    output cfr_pkg::cfr_stat_t                stat,
    output logic                              neg,
    output logic [cfr_pkg::H_W-1:0]           h_out,
    output logic [cfr_pkg::DEN_W-1:0]         k_out
);
    import cfr_pkg::*;

    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [VALUE_W-1:0]  d_reg, d_next;
    logic [SHIFT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [H_W-1:0]      h0_reg, h0_next, h1_reg, h1_next, hacc_reg, hacc_next;
    logic [DEN_W-1:0]    k0_reg, k0_next, k1_reg, k1_next, kacc_reg, kacc_next;

    logic [VALUE_W-1:0]  raw;
    logic [VALUE_W:0]    d_dbl;
    logic                qbit;
    logic [DEN_W+1:0]    kmul;
    logic [H_W+1:0]      hmul;
    logic [DEN_W:0]      k2;
    logic [VALUE_W-1:0]  h2;

    // one restoring division bit plus horner step of a*k1 and a*h1
    always_comb
    begin
        raw   = value_fixed;
        d_dbl = {d_reg, 1'b0};
        qbit  = rem_reg >= d_reg;
        kmul  = {1'b0, kacc_reg, 1'b0} + {2'b00, (qbit ? k1_reg : '0)};
        hmul  = {1'b0, hacc_reg, 1'b0} + {2'b00, (qbit ? h1_reg : '0)};
        k2    = {1'b0, kacc_reg} + {1'b0, k0_reg};
        h2    = {1'b0, hacc_reg} + {1'b0, h0_reg};

        stat.align_more   = d_dbl <= {1'b0, rem_reg};
        stat.div_overflow = (kmul > {2'b00, limit}) || (hmul[H_W+1:H_W] != 2'b00);
        stat.div_last     = cnt_reg == '0;
        stat.upd_reject   = (k2 > {1'b0, limit}) || h2[VALUE_W-1];
        stat.upd_stop     = (rem_reg == '0) || (step_reg == LAST_STEP);
    end

    always_comb
    begin
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        step_next = step_reg;
        h0_next   = h0_reg;
        h1_next   = h1_reg;
        k0_next   = k0_reg;
        k1_next   = k1_reg;
        hacc_next = hacc_reg;
        kacc_next = kacc_reg;

        if (ctrl.start)
        begin
            neg_next  = raw[VALUE_W-1];
            rem_next  = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
            q_next    = Q_INIT;
            d_next    = VALUE_W'(Q_INIT);
            cnt_next  = '0;
            step_next = '0;
            h0_next   = '0;
            h1_next   = H_W'(1);
            k0_next   = DEN_W'(1);
            k1_next   = '0;
            hacc_next = '0;
            kacc_next = '0;
        end
        else if (ctrl.align_shift)
        begin
            d_next   = d_dbl[VALUE_W-1:0];
            cnt_next = cnt_reg + SHIFT_W'(1);
        end
        else if (ctrl.div_step)
        begin
            if (qbit)
            begin
                rem_next = rem_reg - d_reg;
            end
            kacc_next = kmul[DEN_W-1:0];
            hacc_next = hmul[H_W-1:0];
            d_next    = d_reg >> 1;
            cnt_next  = cnt_reg - SHIFT_W'(1);
        end
        else if (ctrl.update_step && !stat.upd_reject)
        begin
            h0_next = h1_reg;
            h1_next = h2[H_W-1:0];
            k0_next = k1_reg;
            k1_next = k2[DEN_W-1:0];
            if (!stat.upd_stop)
            begin
                rem_next  = VALUE_W'(q_reg);
                q_next    = rem_reg[Q_W-1:0];
                d_next    = VALUE_W'(rem_reg[Q_W-1:0]);
                cnt_next  = '0;
                step_next = step_reg + STEP_W'(1);
                hacc_next = '0;
                kacc_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        cnt_reg  <= cnt_next;
        step_reg <= step_next;
        h0_reg   <= h0_next;
        h1_reg   <= h1_next;
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        hacc_reg <= hacc_next;
        kacc_reg <= kacc_next;
    end

    assign neg   = neg_reg;
    assign h_out = h1_reg;
    assign k_out = k1_reg;

endmodule

### rtl/cfr_fsm.sv
// cfr_fsm: sequencer for align, divide and convergent update phases
// depends on cfr_pkg
module cfr_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               value_valid,
    input  logic               out_free,
    input  cfr_pkg::cfr_stat_t stat,
    output logic               value_stall,
    output cfr_pkg::cfr_ctrl_t ctrl
);
    import cfr_pkg::*;

    cfr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        value_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                value_stall = 1'b0;
                if (value_valid)
                begin
                    ctrl.start = 1'b1;
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (stat.align_more)
                begin
                    ctrl.align_shift = 1'b1;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_overflow)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctrl.update_step = 1'b1;
                if (stat.upd_reject || stat.upd_stop)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/continued_fraction_to_rational.sv
// a request is accepted only in idle; the next one waits until this result is loaded
// each euclid step aligns the divisor, divides and updates; an overflowing step ends mid divide
// one request in flight at a time, and a stalled result register holds off the next request
// the single shift-subtract divider yields one quotient bit per cycle while dividing
// reset: max_denominator returns to 65535, result register empties, block idles
// continued_fraction_to_rational: top level with config and result registers
// depends on cfr_pkg, cfr_fsm, cfr_datapath
module continued_fraction_to_rational (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               max_denominator_wen,
    input  logic [cfr_pkg::DEN_W-1:0]          max_denominator_wdata,
    input  logic                               value_valid,
    output logic                               value_stall,
    input  logic signed [cfr_pkg::VALUE_W-1:0] value_fixed,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [cfr_pkg::VALUE_W-1:0] numerator,
    output logic [cfr_pkg::DEN_W-1:0]          denominator
);
    import cfr_pkg::*;

    logic [DEN_W-1:0]   max_den_reg;
    logic [DEN_W-1:0]   limit;
    logic               result_valid_reg;
    logic [VALUE_W-1:0] numerator_reg, numerator_next;
    logic [DEN_W-1:0]   denominator_reg;
    logic               out_free;
    logic               neg;
    logic [H_W-1:0]     h_out;
    logic [DEN_W-1:0]   k_out;
    cfr_ctrl_t          ctrl;
    cfr_stat_t          stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_den_reg <= MAX_DEN_RESET;
        end
        else if (max_denominator_wen)
        begin
            max_den_reg <= max_denominator_wdata;
        end
    end

    // zero limit acts as one
    assign limit    = (max_den_reg == '0) ? DEN_W'(1) : max_den_reg;
    assign out_free = !result_valid_reg || !result_stall;

    cfr_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .out_free    (out_free),
        .stat        (stat),
        .value_stall (value_stall),
        .ctrl        (ctrl)
    );

    cfr_datapath u_datapath (
        .clk         (clk),
        .ctrl        (ctrl),
        .value_fixed (value_fixed),
        .limit       (limit),
        .stat        (stat),
        .neg         (neg),
        .h_out       (h_out),
        .k_out       (k_out)
    );

    assign numerator_next = neg ? (VALUE_W'(0) - {1'b0, h_out}) : {1'b0, h_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            numerator_reg   <= numerator_next;
            denominator_reg <= k_out;
        end
    end

    assign result_valid = result_valid_reg;
    assign numerator    = numerator_reg;
    assign denominator  = denominator_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
        else $error("request accepted but block not busy");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (denominator != '0) && (denominator <= limit))
        else $error("result denominator out of range");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> result_valid)
        else $error("loaded result not presented");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> out_free)
        else $error("result register overwritten while stalled");
`endif

endmodule

### test/tb_continued_fraction_to_rational.sv
// tb_continued_fraction_to_rational: self-checking bench for the continued fraction block
// directed table of values and limits, then random phases, each result checked in order
// depends on cfr_pkg and continued_fraction_to_rational
module tb_continued_fraction_to_rational;

    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam logic [63:0] NUM_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_PCT    = 17;
    localparam int          HOLD_CYCLES = 400;
    localparam int          STILL_LIMIT = 20000;
    localparam int          SETTLE_WAIT = 300;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 145;
    localparam int          DIR_ROWS    = 23;

    typedef struct packed {
        logic signed [VALUE_W-1:0] num;
        logic [DEN_W-1:0]          den;
    } frac_t;

    typedef struct packed {
        logic [DEN_W-1:0]   limit;
        logic [VALUE_W-1:0] value;
        logic               known;
        logic [VALUE_W-1:0] num;
        logic [DEN_W-1:0]   den;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      max_denominator_wen = 1'b0;
    logic [DEN_W-1:0]          max_denominator_wdata = '0;
    logic                      value_valid = 1'b0;
    logic                      value_stall;
    logic signed [VALUE_W-1:0] value_fixed = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [VALUE_W-1:0] numerator;
    logic [DEN_W-1:0]          denominator;

    logic [DEN_W-1:0] cfg_limit = MAX_DEN_RESET;
    frac_t            pending_fracs[$];
    int               fail_count = 0;
    int               still_cycles = 0;
    bit               idle_on = 1'b1;
    bit               hold_req = 1'b0;

    // limit, value, known, numerator, denominator
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{32'd65535, 64'h0000_0000_0000_0000, 1'b1, 64'd0, 32'd1},
        '{32'd65535, 64'h0000_0005_0000_0000, 1'b1, 64'd5, 32'd1},
        '{32'd65535, 64'hFFFF_FFFD_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFD, 32'd1},
        '{32'd65535, 64'h0000_0000_8000_0000, 1'b1, 64'd1, 32'd2},
        '{32'd65535, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 32'd1},
        '{32'd65535, 64'h8000_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_8000_0000, 32'd1},
        '{32'd65535, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 32'd0},
        '{32'd65535, 64'h0000_0003_243F_6A88, 1'b0, 64'd0, 32'd0},
        '{32'd65535, 64'h0000_0000_0000_0001, 1'b1, 64'd0, 32'd1},
        '{32'd65535, 64'hFFFF_FFFF_8000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2},
        '{32'd0, 64'h0000_0002_4000_0000, 1'b1, 64'd2, 32'd1},
        '{32'd0, 64'hFFFF_FFFD_C000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 32'd1},
        '{32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 32'd0},
        '{32'd1, 64'h0000_0002_C000_0000, 1'b0, 64'd0, 32'd0},
        '{32'd1, 64'h8000_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_8000_0000, 32'd1},
        '{32'd1, 64'h0000_0000_0000_0000, 1'b1, 64'd0, 32'd1},
        '{32'hFFFF_FFFF, 64'h0000_0003_243F_6A88, 1'b0, 64'd0, 32'd0},
        '{32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 32'd0},
        '{32'hFFFF_FFFF, 64'h0000_0000_0000_0001, 1'b1, 64'd0, 32'd1},
        '{32'hFFFF_FFFF, 64'h0000_0000_0000_0003, 1'b0, 64'd0, 32'd0},
        '{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0, 64'd0, 32'd0},
        '{32'hFFFF_FFFF, 64'h8000_0000_0000_0001, 1'b0, 64'd0, 32'd0},
        '{32'd2, 64'h0000_0000_5555_5555, 1'b0, 64'd0, 32'd0}
    };

    continued_fraction_to_rational u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .max_denominator_wen   (max_denominator_wen),
        .max_denominator_wdata (max_denominator_wdata),
        .value_valid           (value_valid),
        .value_stall           (value_stall),
        .value_fixed           (value_fixed),
        .result_valid          (result_valid),
        .result_stall          (result_stall),
        .numerator             (numerator),
        .denominator           (denominator)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic frac_t rational_approx(logic [VALUE_W-1:0] raw, logic [DEN_W-1:0] lim_reg);
        logic        neg;
        logic [63:0] p, q, lim, h0, h1, k0, k1, a, r, h2, k2;
        bit          done;
        frac_t       res;
        neg  = raw[VALUE_W-1];
        p    = neg ? (64'd0 - raw) : raw;
        q    = 64'd1 << FRAC_BITS;
        lim  = (lim_reg == '0) ? 64'd1 : 64'(lim_reg);
        h0   = 64'd0;
        h1   = 64'd1;
        k0   = 64'd1;
        k1   = 64'd0;
        done = 1'b0;
        for (int i = 0; i < MAX_STEPS && !done; i++)
        begin
            a = p / q;
            r = p % q;
            if (k1 != 0 && a > (lim - k0) / k1)
                done = 1'b1;
            else
            begin
                k2 = a * k1 + k0;
                if (k2 > lim)
                    done = 1'b1;
                else if (h1 != 0 && a > (NUM_MAX - h0) / h1)
                    done = 1'b1;
                else
                begin
                    h2 = a * h1 + h0;
                    h0 = h1;
                    h1 = h2;
                    k0 = k1;
                    k1 = k2;
                    if (r == 0)
                        done = 1'b1;
                    else
                    begin
                        p = q;
                        q = r;
                    end
                end
            end
        end
        res.num = neg ? (64'd0 - h1) : h1;
        res.den = k1[DEN_W-1:0];
        return res;
    endfunction

    task automatic push_value(logic [VALUE_W-1:0] v, logic known, logic [VALUE_W-1:0] num,
                              logic [DEN_W-1:0] den);
        frac_t want;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            value_valid <= 1'b0;
            @(posedge clk);
        end
        value_valid <= 1'b1;
        value_fixed <= v;
        do
            @(posedge clk);
        while (value_stall);
        if (known)
        begin
            want.num = num;
            want.den = den;
        end
        else
            want = rational_approx(v, cfg_limit);
        pending_fracs.push_back(want);
    endtask

    task automatic settle_results();
        value_valid <= 1'b0;
        while (pending_fracs.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(logic [DEN_W-1:0] lim);
        max_denominator_wen   <= 1'b1;
        max_denominator_wdata <= lim;
        @(posedge clk);
        cfg_limit = lim;
        max_denominator_wen <= 1'b0;
    endtask

    // result side stall, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else
                result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        frac_t want;
        bit    moved;
        if (rst_n)
        begin
            moved = (value_valid && !value_stall) || (result_valid && !result_stall);
            if (result_valid && !result_stall)
            begin
                if (pending_fracs.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %0d/%0d", numerator, denominator);
                    fail_count++;
                end
                else
                begin
                    want = pending_fracs.pop_front();
                    if (numerator !== want.num || denominator !== want.den)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: got %0d/%0d expected %0d/%0d",
                                     numerator, denominator, want.num, want.den);
                        fail_count++;
                    end
                end
            end
            still_cycles = moved ? 0 : still_cycles + 1;
            if (still_cycles >= STILL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", STILL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] v;
        logic [DEN_W-1:0]   lim;
        int                 kind;
        int                 n;
        int                 d;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].limit != cfg_limit)
            begin
                settle_results();
                set_limit(dir_rows[i].limit);
            end
            push_value(dir_rows[i].value, dir_rows[i].known, dir_rows[i].num, dir_rows[i].den);
        end
        settle_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: lim = 32'hFFFF_FFFF;
                1: lim = 32'd1;
                2: lim = 32'd0;
                default:
                begin
                    kind = $urandom_range(2);
                    if (kind == 0)
                        lim = $urandom;
                    else if (kind == 1)
                        lim = $urandom_range(255, 1);
                    else
                        lim = $urandom_range(1 << 20, 256);
                end
            endcase
            set_limit(lim);
            idle_on = (ph != 5);
            if (ph == 3)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                kind = $urandom_range(3);
                case (kind)
                    0: v = {$urandom, $urandom};
                    1: v = $signed({$urandom, $urandom}) >>> $urandom_range(63);
                    2: v = {$urandom, 32'd0};
                    default:
                    begin
                        n = $urandom_range(1000, 1);
                        d = $urandom_range(1000, 1);
                        v = {32'(n), 32'd0} / 64'(d);
                        if ($urandom_range(1))
                            v = 64'd0 - v;
                    end
                endcase
                push_value(v, 1'b0, '0, '0);
            end
            settle_results();
        end
        idle_on = 1'b1;

        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0 && pending_fracs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/cfr_pkg.sv
rtl/cfr_datapath.sv
rtl/cfr_fsm.sv
rtl/continued_fraction_to_rational.sv
test/tb_continued_fraction_to_rational.sv
